FILE: rtl/scp_pkg.sv
// Shared types for the sphere pair contact block.
package scp_pkg;

    // Per-lane tag carried alongside each divider lane.
    typedef struct packed {
        logic neg;     // Result component is negative.
        logic degen;   // Centers coincide; the divider output is ignored.
        logic gneg;    // Gap is negative, which is the hit flag.
    } t_div_tag;

endpackage

FILE: rtl/scp_sqrt_cell.sv
// Square root chain cell: settles one root bit per enabled cycle.
module scp_sqrt_cell #(
    parameter int RW = 33,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [RW:0]     i_rem,
    input  logic [RW-1:0]   i_root,
    input  logic [2*RW-1:0] i_rad,
    input  logic [PW-1:0]   i_pay,
    output logic [RW:0]     o_rem,
    output logic [RW-1:0]   o_root,
    output logic [2*RW-1:0] o_rad,
    output logic [PW-1:0]   o_pay
);
    logic [RW+2:0] w_a;
    logic [RW+2:0] w_b;
    logic [RW+2:0] w_diff;
    logic          w_ge;

    assign w_a    = {i_rem, i_rad[2*RW-1:2*RW-2]};
    assign w_b    = {1'b0, i_root, 2'b01};
    assign w_diff = w_a - w_b;
    assign w_ge   = (w_a >= w_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_ge ? w_diff[RW:0] : w_a[RW:0];
            o_root <= {i_root[RW-2:0], w_ge};
            o_rad  <= {i_rad[2*RW-3:0], 2'b00};
            o_pay  <= i_pay;
        end
    end
endmodule

FILE: rtl/scp_div_cell.sv
// Restoring divider chain cell: settles one quotient bit per enabled cycle.
module scp_div_cell #(
    parameter int DW = 33
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DW-1:0]     i_rem,
    input  logic [DW-1:0]     i_den,
    input  logic [DW-1:0]     i_num,
    input  logic [DW-1:0]     i_quo,
    input  scp_pkg::t_div_tag i_tag,
    output logic [DW-1:0]     o_rem,
    output logic [DW-1:0]     o_den,
    output logic [DW-1:0]     o_num,
    output logic [DW-1:0]     o_quo,
    output scp_pkg::t_div_tag o_tag
);
    logic [DW:0] w_a;
    logic [DW:0] w_b;
    logic [DW:0] w_diff;
    logic        w_ge;

    assign w_a    = {i_rem, i_num[DW-1]};
    assign w_b    = {1'b0, i_den};
    assign w_diff = w_a - w_b;
    assign w_ge   = (w_a >= w_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_diff[DW-1:0] : w_a[DW-1:0];
            o_den <= i_den;
            o_num <= {i_num[DW-2:0], 1'b0};
            o_quo <= {i_quo[DW-2:0], w_ge};
            o_tag <= i_tag;
        end
    end
endmodule

FILE: rtl/sphere_pair_contact.sv
// Sphere pair contact test. Each input transfer carries two spheres (signed
// fixed-point center, unsigned radius); each output transfer carries the hit
// flag, the push vector gap * d / |d| saturated to COORD_WIDTH bits, a
// degenerate flag for coincident centers and a saturation flag. The block is
// fully pipelined and accepts one pair per cycle while the pipeline is not
// held. Most of its stages are the square root chain (one cell per root bit,
// COORD_WIDTH+1 cells) and the divider chains (one cell per quotient bit,
// COORD_WIDTH+1 cells, three lanes side by side). A two-entry output stage
// lets one more result enter while a result waits; when both entries are
// full the whole pipeline holds.
module sphere_pair_contact #(
    parameter int COORD_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // Fields from bit 0 up: first_center_x, first_center_y, first_center_z,
    // first_radius, second_center_x, second_center_y, second_center_z,
    // second_radius, zero fill.
    input  logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // Fields from bit 0 up: hit, push_x, push_y, push_z, degenerate,
    // saturated, zero fill.
    output logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] o_m_axis_tdata
);
    localparam int W   = COORD_WIDTH;
    localparam int RW  = W + 1;            // Root and quotient width.
    localparam int SW  = 2 * RW;           // Squared length width.
    localparam int PW  = 3 * RW + W;       // Payload through the root chain.
    localparam int NV  = 2 * W + 7;        // Pipeline stages before the output.
    localparam int OW  = ((3*W+3+7)/8)*8;
    localparam int RPW = W - 1;            // Radius width.

    // Input fields.
    logic [W-1:0]   w_c1x, w_c1y, w_c1z, w_c2x, w_c2y, w_c2z;
    logic [RPW-1:0] w_r1, w_r2;
    assign w_c1x = i_s_axis_tdata[W-1:0];
    assign w_c1y = i_s_axis_tdata[2*W-1:W];
    assign w_c1z = i_s_axis_tdata[3*W-1:2*W];
    assign w_r1  = i_s_axis_tdata[4*W-2:3*W];
    assign w_c2x = i_s_axis_tdata[5*W-2:4*W-1];
    assign w_c2y = i_s_axis_tdata[6*W-2:5*W-1];
    assign w_c2z = i_s_axis_tdata[7*W-2:6*W-1];
    assign w_r2  = i_s_axis_tdata[8*W-3:7*W-1];

    logic          w_en;
    logic [NV-1:0] r_vld;
    logic          r_out_v, r_skid_v;
    logic [OW-1:0] r_out, r_skid;

    // The pipeline moves as one; it holds only when the skid entry is in use.
    assign w_en            = !r_skid_v;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_s_axis_tvalid};
        end
    end

    // Stage A: center difference and radius sum, both exact.
    logic [RW-1:0] r_da [3];
    logic [W-1:0]  r_rsum_a;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_da[0]  <= {w_c2x[W-1], w_c2x} - {w_c1x[W-1], w_c1x};
            r_da[1]  <= {w_c2y[W-1], w_c2y} - {w_c1y[W-1], w_c1y};
            r_da[2]  <= {w_c2z[W-1], w_c2z} - {w_c1z[W-1], w_c1z};
            r_rsum_a <= {1'b0, w_r1} + {1'b0, w_r2};
        end
    end

    // Stage B: squares of the component magnitudes.
    logic [RW-1:0] w_mag_a [3];
    logic [SW-1:0] r_sq [3];
    logic [RW-1:0] r_db [3];
    logic [W-1:0]  r_rsum_b;
    for (genvar g = 0; g < 3; g++) begin : g_mag_a
        assign w_mag_a[g] = r_da[g][RW-1] ? (~r_da[g] + 1'b1) : r_da[g];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= SW'(w_mag_a[k] * w_mag_a[k]);
                r_db[k] <= r_da[k];
            end
            r_rsum_b <= r_rsum_a;
        end
    end

    // Stage C: squared length.
    logic [SW-1:0] r_ssum;
    logic [PW-1:0] r_pay_c;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ssum  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_pay_c <= {r_db[2], r_db[1], r_db[0], r_rsum_b};
        end
    end

    // Square root chain.
    logic [RW:0]   w_srem  [RW+1];
    logic [RW-1:0] w_sroot [RW+1];
    logic [SW-1:0] w_srad  [RW+1];
    logic [PW-1:0] w_spay  [RW+1];
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = r_ssum;
    assign w_spay[0]  = r_pay_c;
    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        scp_sqrt_cell #(.RW(RW), .PW(PW)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_srem[g]),
            .i_root(w_sroot[g]),
            .i_rad (w_srad[g]),
            .i_pay (w_spay[g]),
            .o_rem (w_srem[g+1]),
            .o_root(w_sroot[g+1]),
            .o_rad (w_srad[g+1]),
            .o_pay (w_spay[g+1])
        );
    end

    // Gap stage: gap = length - radius sum, its sign and magnitude.
    logic [RW-1:0] w_len;
    logic [W-1:0]  w_rsum_s;
    logic [RW-1:0] w_ds [3];
    logic [RW:0]   w_gap;
    logic          w_gneg;
    assign w_len    = w_sroot[RW];
    assign w_rsum_s = w_spay[RW][W-1:0];
    for (genvar g = 0; g < 3; g++) begin : g_ds
        assign w_ds[g] = w_spay[RW][W+(g+1)*RW-1:W+g*RW];
    end
    assign w_gap  = {1'b0, w_len} - {2'b00, w_rsum_s};
    assign w_gneg = w_gap[RW];

    logic [RW-1:0]     r_gmag, r_len_g;
    logic [RW-1:0]     r_dmag [3];
    scp_pkg::t_div_tag r_tag_g [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gmag  <= w_gneg ? RW'(~w_gap + 1'b1) : w_gap[RW-1:0];
            r_len_g <= w_len;
            for (int k = 0; k < 3; k++) begin
                r_dmag[k]        <= w_ds[k][RW-1] ? (~w_ds[k] + 1'b1) : w_ds[k];
                r_tag_g[k].neg   <= w_gneg ^ w_ds[k][RW-1];
                r_tag_g[k].degen <= (w_len == '0);
                r_tag_g[k].gneg  <= w_gneg;
            end
        end
    end

    // Product stage: |gap| * |d_i|.
    logic [SW-1:0]     r_prod [3];
    logic [RW-1:0]     r_len_p;
    scp_pkg::t_div_tag r_tag_p [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k]  <= SW'(r_gmag * r_dmag[k]);
                r_tag_p[k] <= r_tag_g[k];
            end
            r_len_p <= r_len_g;
        end
    end

    // Divider chains, one lane per component. The quotient never exceeds |gap|,
    // so the upper half of the product is already below the length.
    logic [RW-1:0]     w_drem [3][RW+1];
    logic [RW-1:0]     w_dden [3][RW+1];
    logic [RW-1:0]     w_dnum [3][RW+1];
    logic [RW-1:0]     w_dquo [3][RW+1];
    scp_pkg::t_div_tag w_dtag [3][RW+1];
    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_drem[l][0] = r_prod[l][SW-1:RW];
        assign w_dden[l][0] = r_len_p;
        assign w_dnum[l][0] = r_prod[l][RW-1:0];
        assign w_dquo[l][0] = '0;
        assign w_dtag[l][0] = r_tag_p[l];
        for (genvar g = 0; g < RW; g++) begin : g_div
            scp_div_cell #(.DW(RW)) u_cell (
                .i_clk(i_clk),
                .i_en (w_en),
                .i_rem(w_drem[l][g]),
                .i_den(w_dden[l][g]),
                .i_num(w_dnum[l][g]),
                .i_quo(w_dquo[l][g]),
                .i_tag(w_dtag[l][g]),
                .o_rem(w_drem[l][g+1]),
                .o_den(w_dden[l][g+1]),
                .o_num(w_dnum[l][g+1]),
                .o_quo(w_dquo[l][g+1]),
                .o_tag(w_dtag[l][g+1])
            );
        end
    end

    // Sign, saturation and packing of the finished result.
    localparam logic [RW-1:0] HALF = RW'(1) << (W - 1);
    logic [W-1:0] w_res [3];
    logic [2:0]   w_sat;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_res[k] = '0;
            w_sat[k] = 1'b0;
            if (!w_dtag[k][RW].degen) begin
                if (w_dtag[k][RW].neg) begin
                    if (w_dquo[k][RW] > HALF) begin
                        w_res[k] = {1'b1, {(W-1){1'b0}}};
                        w_sat[k] = 1'b1;
                    end else begin
                        w_res[k] = W'(~w_dquo[k][RW] + 1'b1);
                    end
                end else begin
                    if (w_dquo[k][RW] > HALF - 1'b1) begin
                        w_res[k] = {1'b0, {(W-1){1'b1}}};
                        w_sat[k] = 1'b1;
                    end else begin
                        w_res[k] = w_dquo[k][RW][W-1:0];
                    end
                end
            end
        end
    end

    logic [OW-1:0] w_new;
    assign w_new = OW'({|w_sat, w_dtag[0][RW].degen, w_res[2], w_res[1], w_res[0],
                        w_dtag[0][RW].gneg});

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_vld[NV-1];
            end
        end else if (r_vld[NV-1]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : w_new;
        end else if (w_en) begin
            r_skid <= w_new;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out;
endmodule

FILE: rtl/scp_checker.sv
// Port-level checks for the sphere pair contact block, bound to the top level.
module scp_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_s_axis_tready,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] o_m_axis_tdata
);
    localparam int W = COORD_WIDTH;
    logic [W-1:0] w_px, w_py, w_pz;
    logic         w_degen, w_sat;
    logic [W-1:0] w_max, w_min;
    assign w_px    = o_m_axis_tdata[W:1];
    assign w_py    = o_m_axis_tdata[2*W:W+1];
    assign w_pz    = o_m_axis_tdata[3*W:2*W+1];
    assign w_degen = o_m_axis_tdata[3*W+1];
    assign w_sat   = o_m_axis_tdata[3*W+2];
    assign w_max   = {1'b0, {(W-1){1'b1}}};
    assign w_min   = {1'b1, {(W-1){1'b0}}};

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // The input only stalls while a result is waiting at the output.
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result waiting");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_degen |->
            w_px == '0 && w_py == '0 && w_pz == '0 && !w_sat)
        else $error("degenerate result with nonzero push");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_sat |->
            w_px == w_max || w_px == w_min || w_py == w_max || w_py == w_min ||
            w_pz == w_max || w_pz == w_min)
        else $error("saturation flag without a clamped component");
endmodule

bind sphere_pair_contact scp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_scp_checker (.*);

FILE: sim/sphere_pair_contact_test.sv
// Self-checking testbench for the sphere pair contact block.
`timescale 1ns / 1ps

module sphere_pair_contact_test;

    localparam int CW        = 32;
    localparam int IN_BITS   = ((8*CW-2+7)/8)*8;
    localparam int OUT_BITS  = ((3*CW+3+7)/8)*8;
    localparam int N_RANDOM  = 400;
    localparam int N_ROWS    = 14;
    localparam int CYCLE_CAP = 300000;

    typedef struct packed {
        logic signed [31:0] fcx, fcy, fcz;
        logic [30:0]        fr;
        logic signed [31:0] scx, scy, scz;
        logic [30:0]        sr;
    } sphere_pair_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] px, py, pz;
        logic               degen;
        logic               sat;
    } contact_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    // Fields from bit 0 up: first_center_x, first_center_y, first_center_z,
    // first_radius, second_center_x, second_center_y, second_center_z,
    // second_radius, zero fill.
    logic [IN_BITS-1:0]  i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    // Fields from bit 0 up: hit, push_x, push_y, push_z, degenerate,
    // saturated, zero fill.
    logic [OUT_BITS-1:0] o_m_axis_tdata;

    sphere_pair_contact #(.COORD_WIDTH(CW)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    contact_t expected_contacts[$];
    int       error_count;
    int       cycle_count;
    int       pairs_sent;
    int       contacts_seen;
    int       hits_seen;
    int       degens_seen;
    int       sats_seen;
    logic     quiet_stretch;     // No idling on either side while set.
    logic     hold_request;      // Asks the receiver for one long hold-off.

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Exact contact computation: center difference, floor square root of the
    // squared length, gap against the radius sum, then gap * d / L per axis,
    // truncated toward zero and clamped to the signed 32-bit range.
    function automatic contact_t predict_contact(sphere_pair_t p);
        logic [32:0]        d[3];
        logic [32:0]        mag[3];
        logic [66:0]        sq_len;
        logic [33:0]        root;
        logic [33:0]        cand;
        logic [67:0]        cand_sq;
        logic [32:0]        rsum;
        logic signed [35:0] gap;
        logic [35:0]        gmag;
        logic               gneg;
        logic               neg;
        logic [127:0]       quot;
        logic [31:0]        push[3];
        contact_t           c;
        d[0] = {p.scx[31], p.scx} - {p.fcx[31], p.fcx};
        d[1] = {p.scy[31], p.scy} - {p.fcy[31], p.fcy};
        d[2] = {p.scz[31], p.scz} - {p.fcz[31], p.fcz};
        sq_len = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = d[i][32] ? -d[i] : d[i];
            sq_len = sq_len + 67'(mag[i]) * 67'(mag[i]);
        end
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand    = root | (34'd1 << b);
            cand_sq = 68'(cand) * 68'(cand);
            if (cand_sq <= 68'(sq_len)) begin
                root = cand;
            end
        end
        rsum = 33'(p.fr) + 33'(p.sr);
        gap  = $signed({2'b00, root}) - $signed({3'b000, rsum});
        gneg = gap < 0;
        gmag = gneg ? 36'(-gap) : 36'(gap);
        c.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            push[i] = '0;
            if (root != 0) begin
                quot = (128'(gmag) * 128'(mag[i])) / 128'(root);
                neg  = gneg ^ d[i][32];
                if (quot != 0) begin
                    if (neg) begin
                        if (quot > 128'h8000_0000) begin
                            quot  = 128'h8000_0000;
                            c.sat = 1'b1;
                        end
                        push[i] = -quot[31:0];
                    end else begin
                        if (quot > 128'h7FFF_FFFF) begin
                            quot  = 128'h7FFF_FFFF;
                            c.sat = 1'b1;
                        end
                        push[i] = quot[31:0];
                    end
                end
            end
        end
        c.hit   = gneg;
        c.degen = (root == 0);
        c.px    = push[0];
        c.py    = push[1];
        c.pz    = push[2];
        return c;
    endfunction

    function automatic logic [IN_BITS-1:0] pack_pair(sphere_pair_t p);
        return {2'b00, p.sr, p.scz, p.scy, p.scx, p.fr, p.fcz, p.fcy, p.fcx};
    endfunction

    function automatic contact_t unpack_contact(logic [OUT_BITS-1:0] v);
        contact_t c;
        c.hit   = v[0];
        c.px    = v[32:1];
        c.py    = v[64:33];
        c.pz    = v[96:65];
        c.degen = v[97];
        c.sat   = v[98];
        return c;
    endfunction

    function automatic sphere_pair_t random_pair();
        sphere_pair_t p;
        int           kind;
        logic [31:0]  spread;
        logic [255:0] raw;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            // Any bit pattern at all.
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom};
            p = raw[253:0];
        end else if (kind < 25) begin
            // Coincident centers with random radii, some of them zero.
            p.fcx = $urandom; p.fcy = $urandom; p.fcz = $urandom;
            p.scx = p.fcx;    p.scy = p.fcy;    p.scz = p.fcz;
            p.fr  = ($urandom_range(0, 3) == 0) ? '0 : 31'($urandom);
            p.sr  = ($urandom_range(0, 3) == 0) ? '0 : 31'($urandom);
        end else begin
            // Nearby spheres, so that hits and misses come about equally.
            spread = 32'd1 << $urandom_range(4, 26);
            p.fcx = $urandom;
            p.fcy = $urandom;
            p.fcz = $urandom;
            p.scx = p.fcx + $signed($urandom_range(0, 2*spread) - spread);
            p.scy = p.fcy + $signed($urandom_range(0, 2*spread) - spread);
            p.scz = p.fcz + $signed($urandom_range(0, 2*spread) - spread);
            p.fr  = 31'($urandom_range(0, spread));
            p.sr  = 31'($urandom_range(0, spread));
            if (kind < 35) begin
                // Aligned on one axis.
                p.scy = p.fcy;
                p.scz = p.fcz;
            end
        end
        return p;
    endfunction

    // Offers one pair and waits for its transfer; the expectation is queued
    // at the accepting edge.
    task automatic send_pair(sphere_pair_t p, logic known, contact_t want);
        if (!quiet_stretch) begin
            while ($urandom_range(0, 99) < 11) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pack_pair(p);
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_contacts.push_back(known ? want : predict_contact(p));
        pairs_sent++;
    endtask

    task automatic drain_contacts();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_contacts.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Directed rows: the ones with a typed-in result are read straight off
    // the definition; the rest go through the predictor.
    sphere_pair_t dir_pair[N_ROWS];
    logic         dir_known[N_ROWS];
    contact_t     dir_want[N_ROWS];

    task automatic set_row(int r, sphere_pair_t p, logic known, contact_t want);
        dir_pair[r]  = p;
        dir_known[r] = known;
        dir_want[r]  = want;
    endtask

    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic [30:0]        RMAX = 31'h7FFF_FFFF;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial begin
        contact_t none;
        none = '0;
        // Both spheres at the origin with zero radii: degenerate, no hit.
        set_row(0, '0, 1'b1, '{1'b0, 0, 0, 0, 1'b1, 1'b0});
        // Coincident centers with positive radii: degenerate hit.
        set_row(1, '{5*ONE, 5*ONE, 5*ONE, 31'(ONE), 5*ONE, 5*ONE, 5*ONE, 31'(2*ONE)},
                1'b1, '{1'b1, 0, 0, 0, 1'b1, 1'b0});
        // Ten units apart on x with zero radii: the push is the distance.
        set_row(2, '{0, 0, 0, '0, 10*ONE, 0, 0, '0}, 1'b1,
                '{1'b0, 10*ONE, 0, 0, 1'b0, 1'b0});
        // Same, with radii of eight each: overlap of six pushes back.
        set_row(3, '{0, 0, 0, 31'(8*ONE), 10*ONE, 0, 0, 31'(8*ONE)},
                1'b1, '{1'b1, -6*ONE, 0, 0, 1'b0, 1'b0});
        // Opposite extremes: zero radii saturate, the largest radii do not.
        set_row(4, '{CMIN, CMIN, CMIN, '0, CMAX, CMAX, CMAX, '0}, 1'b0, none);
        set_row(5, '{CMAX, CMAX, CMAX, RMAX, CMIN, CMIN, CMIN, RMAX}, 1'b0, none);
        set_row(6, '{CMAX, 0, 0, RMAX, CMIN, 0, 0, RMAX}, 1'b0, none);
        // Coincident extremes with the largest radii.
        set_row(7, '{CMIN, CMAX, CMIN, RMAX, CMIN, CMAX, CMIN, RMAX},
                1'b1, '{1'b1, 0, 0, 0, 1'b1, 1'b0});
        // Smallest steps, where the floor square root of three is one.
        set_row(8, '{0, 0, 0, '0, 1, 1, 1, '0}, 1'b0, none);
        set_row(9, '{0, 0, 0, 31'd3, -1, 1, -1, '0}, 1'b0, none);
        // Distance exactly equal to the radius sum: gap zero, no hit.
        set_row(10, '{0, 0, 0, 31'(3*ONE), 0, 4*ONE, 0, 31'(ONE)}, 1'b1,
                '{1'b0, 0, 0, 0, 1'b0, 1'b0});
        set_row(11, '{ONE, -ONE, ONE, 31'h5555_5555, -ONE, ONE, -ONE, 31'h2AAA_AAAA},
                1'b0, none);
        set_row(12, '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 31'h2AAA_AAAA,
                      32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 31'h5555_5555},
                1'b0, none);
        set_row(13, '{CMAX, CMAX, CMAX, '0, CMAX, CMAX, CMAX - 1, '0}, 1'b0, none);
    end

    // Stimulus.
    initial begin
        error_count     = 0;
        pairs_sent      = 0;
        quiet_stretch   = 1'b0;
        hold_request    = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            send_pair(dir_pair[r], dir_known[r], dir_want[r]);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_stretch = (n >= 150 && n < 250);
            if (n == 80) begin
                // The receiver holds off while transfers keep coming, so the
                // pipeline fills and stalls the input.
                hold_request = 1'b1;
            end
            if (n == 300) begin
                // The sender pauses until every result has come back.
                drain_contacts();
            end
            send_pair(random_pair(), 1'b0, '0);
        end
        drain_contacts();
        repeat (80) @(posedge i_clk);

        $display("Sent %0d sphere pairs (%0d directed): %0d hits, %0d degenerate,",
                 pairs_sent, N_ROWS, hits_seen, degens_seen);
        $display("%0d saturated, with random stalls and one long output hold-off.",
                 sats_seen);
        if (error_count == 0 && expected_contacts.size() == 0) begin
            $display("sphere_pair_contact_test: clean");
        end else begin
            $display("sphere_pair_contact_test: errors");
        end
        $finish;
    end

    // Receiver: random stalls, a long hold-off on request, none in the
    // quiet stretch.
    initial begin
        int hold_left;
        logic hold_done;
        hold_left       = 0;
        hold_done       = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (quiet_stretch) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // Result checker at the rising edge.
    always @(posedge i_clk) begin
        contact_t got;
        contact_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = unpack_contact(o_m_axis_tdata);
            contacts_seen++;
            hits_seen   += got.hit;
            degens_seen += got.degen;
            sats_seen   += got.sat;
            if (expected_contacts.size() == 0) begin
                $error("Result transfer with no pair outstanding");
                error_count++;
            end else begin
                want = expected_contacts.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    error_count++;
                end
                if (got.px !== want.px) begin
                    $error("push_x: expected %0d, got %0d", want.px, got.px);
                    error_count++;
                end
                if (got.py !== want.py) begin
                    $error("push_y: expected %0d, got %0d", want.py, got.py);
                    error_count++;
                end
                if (got.pz !== want.pz) begin
                    $error("push_z: expected %0d, got %0d", want.pz, got.pz);
                    error_count++;
                end
                if (got.degen !== want.degen) begin
                    $error("degenerate: expected %0d, got %0d", want.degen, got.degen);
                    error_count++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, got.sat);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cycle_count   = 0;
        contacts_seen = 0;
        hits_seen     = 0;
        degens_seen   = 0;
        sats_seen     = 0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Timed out with %0d results outstanding.", expected_contacts.size());
            $display("sphere_pair_contact_test: errors");
            $finish;
        end
    end

endmodule

FILE: sphere_pair_contact.f
rtl/scp_pkg.sv
rtl/scp_sqrt_cell.sv
rtl/scp_div_cell.sv
rtl/sphere_pair_contact.sv
rtl/scp_checker.sv
sim/sphere_pair_contact_test.sv
